@@ hdl/assert_macros.svh @@
// Assertion macros shared by the ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ring buffer assertion failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ring buffer assertion failed");

`endif

@@ hdl/brb_pkg.sv @@
// Package: sizes, request codes, FSM states and controller/datapath structs.
`default_nettype none

package brb_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;
	localparam int BYTE_W      = 8;
	localparam int REQ_W       = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 3'd0,
		REQ_FPUSH  = 3'd1,
		REQ_POP    = 3'd2,
		REQ_DROP   = 3'd3,
		REQ_REWIND = 3'd4,
		REQ_CANCEL = 3'd5,
		REQ_FLUSH  = 3'd6,
		REQ_SEARCH = 3'd7
	} brb_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SCAN,
		ST_FIN
	} brb_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic exec;
		logic pop_rd;
		logic pop_fin;
		logic srch_start;
		logic srch_step;
		logic srch_fin;
	} brb_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		brb_req_t req;
		logic     fill_nz;
		logic     hit;
		logic     scan_done;
	} brb_sts_t;

endpackage

`default_nettype wire

@@ hdl/brb_ctrl.sv @@
// Controller: request sequencing FSM and output valid register.
`default_nettype none
`include "assert_macros.svh"

module brb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire brb_pkg::brb_sts_t sts,
	output brb_pkg::brb_cmd_t      cmd
);

	brb_pkg::brb_state_t state_q, state_n;
	logic out_valid_q;
	logic out_free;
	logic load_any;
	logic pop_nz;

	assign out_free = !out_valid_q || out_ready;
	assign pop_nz   = (sts.req == brb_pkg::REQ_POP) && sts.fill_nz;
	assign load_any = cmd.exec || cmd.pop_fin || cmd.srch_fin;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			brb_pkg::ST_IDLE: begin
				if (in_valid && in_ready) state_n = brb_pkg::ST_EXEC;
			end
			brb_pkg::ST_EXEC: begin
				if (pop_nz) state_n = brb_pkg::ST_POP;
				else if (sts.req == brb_pkg::REQ_SEARCH) state_n = brb_pkg::ST_SCAN;
				else if (out_free) state_n = brb_pkg::ST_IDLE;
			end
			brb_pkg::ST_POP: begin
				if (out_free) state_n = brb_pkg::ST_IDLE;
			end
			brb_pkg::ST_SCAN: begin
				if (sts.hit || sts.scan_done) state_n = brb_pkg::ST_FIN;
			end
			brb_pkg::ST_FIN: begin
				if (out_free) state_n = brb_pkg::ST_IDLE;
			end
			default: state_n = brb_pkg::ST_IDLE;
		endcase
	end

	// Handshakes and datapath commands
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			brb_pkg::ST_IDLE: begin
				cfg_ready  = 1'b1;
				in_ready   = !cfg_valid;
				cmd.cfg_wr = cfg_valid;
				cmd.accept = in_valid && !cfg_valid;
			end
			brb_pkg::ST_EXEC: begin
				cmd.pop_rd     = pop_nz;
				cmd.srch_start = (sts.req == brb_pkg::REQ_SEARCH);
				cmd.exec       = !pop_nz && (sts.req != brb_pkg::REQ_SEARCH) && out_free;
			end
			brb_pkg::ST_POP: begin
				cmd.pop_fin = out_free;
			end
			brb_pkg::ST_SCAN: begin
				cmd.srch_step = 1'b1;
			end
			brb_pkg::ST_FIN: begin
				cmd.srch_fin = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_any) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// A result is only loaded into a free output register
	`ASSERT_IMP(a_load_free, clk, arst_n, load_any, out_free)
	// An accepted request moves to the execute state in the following cycle
	`ASSERT_NXT(a_accept_exec, clk, arst_n, cmd.accept, state_q == brb_pkg::ST_EXEC)
	// Config is never written while a request is in flight
	`ASSERT_IMP(a_cfg_idle, clk, arst_n, cmd.cfg_wr, !cmd.accept)

endmodule

`default_nettype wire

@@ hdl/brb_dp.sv @@
// Datapath: byte store, pointers, fill counter, search scan and result register.
`default_nettype none
`include "assert_macros.svh"

module brb_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire brb_pkg::brb_cmd_t            cmd,
	output brb_pkg::brb_sts_t                 sts,
	input  wire logic [brb_pkg::CNT_W-1:0]    capacity,
	input  wire logic [brb_pkg::REQ_W-1:0]    req_type,
	input  wire logic [brb_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic [brb_pkg::CNT_W-1:0]    count,
	output logic [brb_pkg::BYTE_W-1:0]        out_byte,
	output logic [brb_pkg::CNT_W-1:0]         done_count,
	output logic [brb_pkg::CNT_W-1:0]         fill_level,
	output logic                              is_empty,
	output logic                              is_full,
	output logic                              overwrote,
	output logic                              found,
	output logic [brb_pkg::PTR_W-1:0]         position
);

	localparam int PW = brb_pkg::PTR_W;
	localparam int CW = brb_pkg::CNT_W;
	localparam int BW = brb_pkg::BYTE_W;

	// Pointer advance with wrap at the capacity
	function automatic logic [PW-1:0] ptr_fwd(input logic [PW-1:0] p,
			input logic [CW-1:0] n, input logic [CW-1:0] cap);
		logic [CW-1:0] s;
		s = {1'b0, p} + n;
		if (s >= cap) s = s - cap;
		return s[PW-1:0];
	endfunction

	// Pointer step back with wrap at the capacity
	function automatic logic [PW-1:0] ptr_back(input logic [PW-1:0] p,
			input logic [CW-1:0] n, input logic [CW-1:0] cap);
		logic [CW-1:0] r;
		if ({1'b0, p} >= n) r = {1'b0, p} - n;
		else r = {1'b0, p} + cap - n;
		return r[PW-1:0];
	endfunction

	logic [BW-1:0] mem [brb_pkg::STORE_DEPTH];

	logic [CW-1:0]     cap_q;
	logic [PW-1:0]     wp_q, rp_q;
	logic [CW-1:0]     fill_q;
	brb_pkg::brb_req_t req_q;
	logic [BW-1:0]     byte_q;
	logic [CW-1:0]     cnt_q;

	logic [BW-1:0]     rd_data_q;
	logic [PW-1:0]     idx_q;
	logic [CW-1:0]     iss_cnt_q;
	logic              cmp_v_s1;
	logic [PW-1:0]     cmp_pos_s1;
	logic              found_q;
	logic [PW-1:0]     pos_q;

	logic [BW-1:0]     out_byte_q;
	logic [CW-1:0]     done_q, fill_out_q;
	logic              empty_q, full_q, over_q, found_out_q;
	logic [PW-1:0]     pos_out_q;

	logic [PW-1:0]     wp_n, rp_n;
	logic [CW-1:0]     fill_n, done_n;
	logic              over_n, mem_we;
	logic [CW-1:0]     free_c, drop_c, rew_c;
	logic [CW-1:0]     cap_cfg;
	logic              issue;
	logic              rd_en;
	logic [PW-1:0]     rd_addr;
	logic              load_any;
	logic              gap_ok;

	// Clamp written capacity into 1..STORE_DEPTH
	always_comb begin
		if (capacity == '0) cap_cfg = CW'(1);
		else if (capacity > CW'(brb_pkg::STORE_DEPTH)) cap_cfg = CW'(brb_pkg::STORE_DEPTH);
		else cap_cfg = capacity;
	end

	// Request execution: next pointers, fill and result fields
	always_comb begin
		wp_n   = wp_q;
		rp_n   = rp_q;
		fill_n = fill_q;
		done_n = '0;
		over_n = 1'b0;
		mem_we = 1'b0;
		free_c = cap_q - fill_q;
		drop_c = (cnt_q < fill_q) ? cnt_q : fill_q;
		rew_c  = (cnt_q < free_c) ? cnt_q : free_c;
		if (cmd.exec) begin
			unique case (req_q)
				brb_pkg::REQ_PUSH: begin
					if (fill_q < cap_q) begin
						mem_we = 1'b1;
						wp_n   = ptr_fwd(wp_q, CW'(1), cap_q);
						fill_n = fill_q + CW'(1);
						done_n = CW'(1);
					end
				end
				brb_pkg::REQ_FPUSH: begin
					mem_we = 1'b1;
					wp_n   = ptr_fwd(wp_q, CW'(1), cap_q);
					done_n = CW'(1);
					if (fill_q >= cap_q) begin
						rp_n   = ptr_fwd(rp_q, CW'(1), cap_q);
						fill_n = cap_q;
						over_n = 1'b1;
					end else begin
						fill_n = fill_q + CW'(1);
					end
				end
				brb_pkg::REQ_DROP: begin
					rp_n   = ptr_fwd(rp_q, drop_c, cap_q);
					fill_n = fill_q - drop_c;
					done_n = drop_c;
				end
				brb_pkg::REQ_REWIND: begin
					rp_n   = ptr_back(rp_q, rew_c, cap_q);
					fill_n = fill_q + rew_c;
					done_n = rew_c;
				end
				brb_pkg::REQ_CANCEL: begin
					if (fill_q > cnt_q) begin
						wp_n   = ptr_back(wp_q, cnt_q, cap_q);
						fill_n = fill_q - cnt_q;
						done_n = cnt_q;
					end else begin
						done_n = fill_q;
						wp_n   = '0;
						rp_n   = '0;
						fill_n = '0;
					end
				end
				brb_pkg::REQ_FLUSH: begin
					wp_n   = '0;
					rp_n   = '0;
					fill_n = '0;
				end
				default: begin
					// empty pop and search leave the state alone here
					done_n = '0;
				end
			endcase
		end else if (cmd.pop_fin) begin
			rp_n   = ptr_fwd(rp_q, CW'(1), cap_q);
			fill_n = fill_q - CW'(1);
			done_n = CW'(1);
		end
	end

	// Store read port: pop reads at the head, the scan walks idx_q
	assign issue    = cmd.srch_step && (iss_cnt_q < fill_q);
	assign rd_en    = cmd.pop_rd || issue;
	assign rd_addr  = cmd.pop_rd ? rp_q : idx_q;
	assign load_any = cmd.exec || cmd.pop_fin || cmd.srch_fin;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q] <= byte_q;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// Pointers, fill and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CW'(brb_pkg::STORE_DEPTH);
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q  <= cap_cfg;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			fill_q <= fill_n;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= brb_pkg::brb_req_t'(req_type);
			byte_q <= data_byte;
			cnt_q  <= count;
		end
	end

	// Search scan: one read issued per cycle, compared in the cycle after its issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
		end else if (cmd.srch_start) begin
			cmp_v_s1 <= 1'b0;
		end else if (cmd.srch_step) begin
			cmp_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_start) begin
			idx_q     <= rp_q;
			iss_cnt_q <= '0;
			found_q   <= 1'b0;
			pos_q     <= '0;
		end else if (cmd.srch_step) begin
			if (issue) begin
				idx_q      <= ptr_fwd(idx_q, CW'(1), cap_q);
				iss_cnt_q  <= iss_cnt_q + CW'(1);
				cmp_pos_s1 <= iss_cnt_q[PW-1:0];
			end
			if (sts.hit) begin
				found_q <= 1'b1;
				pos_q   <= cmp_pos_s1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_any) begin
			out_byte_q  <= cmd.pop_fin ? rd_data_q : '0;
			done_q      <= done_n;
			fill_out_q  <= fill_n;
			empty_q     <= (fill_n == '0);
			full_q      <= (fill_n == cap_q);
			over_q      <= over_n;
			found_out_q <= cmd.srch_fin && found_q;
			pos_out_q   <= cmd.srch_fin ? pos_q : '0;
		end
	end

	assign sts.req       = req_q;
	assign sts.fill_nz   = (fill_q != '0);
	assign sts.hit       = cmp_v_s1 && (rd_data_q == byte_q);
	assign sts.scan_done = (iss_cnt_q == fill_q) && !cmp_v_s1;

	assign out_byte   = out_byte_q;
	assign done_count = done_q;
	assign fill_level = fill_out_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;
	assign overwrote  = over_q;
	assign found      = found_out_q;
	assign position   = pos_out_q;

	// Write pointer always sits fill bytes past the read pointer
	assign gap_ok = (ptr_fwd(rp_q, fill_q, cap_q) == wp_q);

	`ASSERT_IMP(a_fill_cap, clk, arst_n, 1'b1, (fill_q <= cap_q))
	`ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, (wp_q < cap_q) && (rp_q < cap_q))
	`ASSERT_IMP(a_ptr_gap, clk, arst_n, 1'b1, gap_ok)

endmodule

`default_nettype wire

@@ hdl/byte_ring_buffer_with_rewind_search_core.sv @@
// Top level of the byte ring buffer: controller plus datapath.
// Usage:
//   Requests arrive on the in_valid/in_ready channel (req_type, data_byte,
//   count); each transaction yields exactly one result on the
//   out_valid/out_ready channel. The capacity register is written through
//   cfg_valid/cfg_ready with the value on capacity; a write also flushes the
//   FIFO. Write it only while no request is outstanding.
//   Push, force push, empty pop, drop, rewind, cancel and flush are executed
//   in the execute state, which loads the result register; a pop of a stored
//   byte also passes a pop state because of the registered store read.
//   A search issues one store read per cycle and stops at the first match
//   or once every stored byte has been read and compared, then loads its
//   result from a finish state. The request sequencer handles one request
//   at a time.
//   A new request is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the next request waits to load
//   its result until the output register frees up.
//   Reset: capacity returns to 1024, pointers and fill clear; the byte store
//   is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_buffer_with_rewind_search_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [brb_pkg::CNT_W-1:0]   capacity,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [brb_pkg::REQ_W-1:0]   req_type,
	input  wire logic [brb_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic [brb_pkg::CNT_W-1:0]   count,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [brb_pkg::BYTE_W-1:0]       out_byte,
	output logic [brb_pkg::CNT_W-1:0]        done_count,
	output logic [brb_pkg::CNT_W-1:0]        fill_level,
	output logic                             is_empty,
	output logic                             is_full,
	output logic                             overwrote,
	output logic                             found,
	output logic [brb_pkg::PTR_W-1:0]        position
);

	brb_pkg::brb_cmd_t cmd;
	brb_pkg::brb_sts_t sts;

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.capacity   (capacity),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.count      (count),
		.out_byte   (out_byte),
		.done_count (done_count),
		.fill_level (fill_level),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.overwrote  (overwrote),
		.found      (found),
		.position   (position)
	);

endmodule

`default_nettype wire
